FILE: src/tbeo_pkg.sv
// ----------------------------------------------------------------------------
// tbeo_pkg
// Shared types and constants for the two-bank epoch ownership core.
// ----------------------------------------------------------------------------
package tbeo_pkg;

  // field widths
  localparam int OP_W        = 4;
  localparam int EPOCH_W     = 64;
  localparam int GEN_W       = 63;
  localparam int READER_BITS = 32;

  localparam logic [GEN_W-1:0]       GEN_MAX    = {GEN_W{1'b1}};
  localparam logic [READER_BITS-1:0] READER_MAX = {READER_BITS{1'b1}};

  // command codes
  typedef enum logic [OP_W-1:0] {
    OP_INIT      = 4'd0,
    OP_ACQ_PUB   = 4'd1,
    OP_ACQ_ADM   = 4'd2,
    OP_ACQ_EXACT = 4'd3,
    OP_RELEASE   = 4'd4,
    OP_RESERVE   = 4'd5,
    OP_READY     = 4'd6,
    OP_PUBLISH   = 4'd7,
    OP_ABORT     = 4'd8,
    OP_RETIRE    = 4'd9
  } op_t;

  // answer codes
  typedef enum logic [1:0] {
    ST_DONE     = 2'd0,
    ST_REFUSED  = 2'd1,
    ST_INVALID  = 2'd2,
    ST_PROTOCOL = 2'd3
  } status_t;

  // per-bank lifecycle
  typedef enum logic [2:0] {
    PH_EMPTY     = 3'd0,
    PH_CANDIDATE = 3'd1,
    PH_READY     = 3'd2,
    PH_PUBLISHED = 3'd3,
    PH_RETIRING  = 3'd4
  } phase_t;

  // controller to datapath commands
  typedef struct packed {
    logic capture;
    logic commit;
  } cmd_t;

endpackage

FILE: src/tbeo_ctrl.sv
// ----------------------------------------------------------------------------
// tbeo_ctrl
// Request sequencer: takes one request, lets the datapath evaluate and
// commit it once the result register is free, and owns the result valid.
// ----------------------------------------------------------------------------
module tbeo_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_stall,
  output logic           out_valid,
  input  logic           out_stall,
  output tbeo_pkg::cmd_t cmd
);

  typedef enum logic {
    S_IDLE,
    S_EXEC
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   out_free;

  // result register can take a new answer this cycle
  assign out_free = !out_valid_r || !out_stall;

  assign in_stall    = (state_r != S_IDLE);
  assign out_valid   = out_valid_r;
  assign cmd.capture = (state_r == S_IDLE) && in_valid;
  assign cmd.commit  = (state_r == S_EXEC) && out_free;

  // next state and result valid
  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r;
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // a commit always leaves a result waiting
  a_commit_loads: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit |=> out_valid_r)
    else $error("commit did not raise out_valid");

  // a commit never overwrites a result that is still stalled
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit |-> (!out_valid_r || !out_stall))
    else $error("result overwritten while stalled");

  // a captured request is evaluated next
  a_capture_exec: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.capture |=> (state_r == S_EXEC && !cmd.capture))
    else $error("captured request not evaluated");

endmodule

FILE: src/tbeo_dp.sv
// ----------------------------------------------------------------------------
// tbeo_dp
// Bank state registers, request holding registers, command evaluation and
// the result register.
// ----------------------------------------------------------------------------
module tbeo_dp (
  input  logic                             clk,
  input  logic                             rst_n,
  input  tbeo_pkg::cmd_t                   cmd,
  input  logic [tbeo_pkg::OP_W-1:0]        in_op,
  input  logic [tbeo_pkg::EPOCH_W-1:0]     in_epoch,
  input  logic                             in_bank,
  input  logic [tbeo_pkg::GEN_W-1:0]       in_ticket_generation,
  output logic [1:0]                       out_status,
  output logic [tbeo_pkg::EPOCH_W-1:0]     out_result_epoch,
  output logic                             out_result_bank,
  output logic [tbeo_pkg::GEN_W-1:0]       out_result_generation,
  output logic [tbeo_pkg::EPOCH_W-1:0]     out_prior_epoch,
  output logic                             out_prior_bank
);

  // request holding registers
  logic [tbeo_pkg::OP_W-1:0]    op_r;
  logic [tbeo_pkg::EPOCH_W-1:0] ep_r;
  logic                         bk_r;
  logic [tbeo_pkg::GEN_W-1:0]   tg_r;

  // bank state
  tbeo_pkg::phase_t                 phase_r [2];
  tbeo_pkg::phase_t                 phase_nxt [2];
  logic [tbeo_pkg::EPOCH_W-1:0]     tag_r [2];
  logic [tbeo_pkg::EPOCH_W-1:0]     tag_nxt [2];
  logic [tbeo_pkg::READER_BITS-1:0] rc_r [2];
  logic [tbeo_pkg::READER_BITS-1:0] rc_nxt [2];
  logic [tbeo_pkg::GEN_W-1:0]       gen_r, gen_nxt;
  logic                             live_r, live_nxt;

  // result register
  tbeo_pkg::status_t            st_r, st_nxt;
  logic [tbeo_pkg::EPOCH_W-1:0] res_epoch_r, res_epoch_nxt;
  logic                         res_bank_r, res_bank_nxt;
  logic [tbeo_pkg::GEN_W-1:0]   res_gen_r, res_gen_nxt;
  logic [tbeo_pkg::EPOCH_W-1:0] pri_epoch_r, pri_epoch_nxt;
  logic                         pri_bank_r, pri_bank_nxt;

  // lookup by the request epoch, bank 0 first
  logic ep_zero, ehit0, ehit1, efound, eb;
  assign ep_zero = (ep_r == '0);
  assign ehit0   = !ep_zero && (tag_r[0] == ep_r);
  assign ehit1   = !ep_zero && (tag_r[1] == ep_r);
  assign efound  = ehit0 || ehit1;
  assign eb      = !ehit0;

  // epoch ordering against the live bank
  logic [tbeo_pkg::EPOCH_W-1:0] live_tag;
  logic                         ep_gt_live;
  assign live_tag   = tag_r[live_r];
  assign ep_gt_live = (ep_r > live_tag);

  // acquire lookup: requested epoch, or the live epoch
  logic [tbeo_pkg::EPOCH_W-1:0] req;
  logic                         rhit0, rhit1, rfound, rb, exact;
  tbeo_pkg::phase_t             rph;
  logic [tbeo_pkg::GEN_W-1:0]   tgen;
  assign req    = (op_r == tbeo_pkg::OP_ACQ_PUB || ep_zero) ? live_tag : ep_r;
  assign rhit0  = (req != '0) && (tag_r[0] == req);
  assign rhit1  = (req != '0) && (tag_r[1] == req);
  assign rfound = rhit0 || rhit1;
  assign rb     = !rhit0;
  assign rph    = phase_r[rb];
  assign exact  = (op_r == tbeo_pkg::OP_ACQ_EXACT) && (rph == tbeo_pkg::PH_READY);
  // generation reaches zero at either end (wrap above GEN_MAX, or 1 - 1), which refuses the ticket
  assign tgen   = (rb == live_r) ? gen_r :
                  exact          ? gen_r + 1'b1 : gen_r - 1'b1;

  // pristine check for init
  logic pristine;
  assign pristine = (tag_r[0] == '0) && (tag_r[1] == '0) &&
                    (rc_r[0] == '0) && (rc_r[1] == '0) &&
                    (phase_r[0] == tbeo_pkg::PH_EMPTY) &&
                    (phase_r[1] == tbeo_pkg::PH_EMPTY);

  // command evaluation
  always_comb begin
    phase_nxt     = phase_r;
    tag_nxt       = tag_r;
    rc_nxt        = rc_r;
    gen_nxt       = gen_r;
    live_nxt      = live_r;
    st_nxt        = tbeo_pkg::ST_INVALID;
    res_epoch_nxt = '0;
    res_bank_nxt  = 1'b0;
    res_gen_nxt   = '0;
    pri_epoch_nxt = '0;
    pri_bank_nxt  = 1'b0;
    unique case (op_r)
      tbeo_pkg::OP_INIT: begin
        if (ep_zero) begin
          st_nxt = tbeo_pkg::ST_INVALID;
        end else if (gen_r != '0 || !pristine) begin
          st_nxt = tbeo_pkg::ST_PROTOCOL;
        end else begin
          st_nxt           = tbeo_pkg::ST_DONE;
          tag_nxt[bk_r]    = ep_r;
          phase_nxt[bk_r]  = tbeo_pkg::PH_PUBLISHED;
          gen_nxt          = tbeo_pkg::GEN_W'(1);
          live_nxt         = bk_r;
        end
      end
      tbeo_pkg::OP_ACQ_PUB, tbeo_pkg::OP_ACQ_ADM, tbeo_pkg::OP_ACQ_EXACT: begin
        st_nxt = tbeo_pkg::ST_REFUSED;
        if (!(op_r == tbeo_pkg::OP_ACQ_EXACT && ep_zero) && gen_r != '0 && rfound &&
            (exact || rph == tbeo_pkg::PH_PUBLISHED || rph == tbeo_pkg::PH_RETIRING) &&
            rc_r[rb] != tbeo_pkg::READER_MAX && tgen != '0) begin
          st_nxt        = tbeo_pkg::ST_DONE;
          rc_nxt[rb]    = rc_r[rb] + 1'b1;
          res_epoch_nxt = tag_r[rb];
          res_bank_nxt  = rb;
          res_gen_nxt   = tgen;
        end
      end
      tbeo_pkg::OP_RELEASE: begin
        st_nxt = tbeo_pkg::ST_REFUSED;
        if (tg_r != '0 && !ep_zero && tag_r[bk_r] == ep_r && rc_r[bk_r] != '0) begin
          st_nxt       = tbeo_pkg::ST_DONE;
          rc_nxt[bk_r] = rc_r[bk_r] - 1'b1;
        end
      end
      tbeo_pkg::OP_RESERVE: begin
        if (gen_r == '0 || live_tag == '0) begin
          st_nxt = tbeo_pkg::ST_PROTOCOL;
        end else if (ep_zero || !ep_gt_live) begin
          st_nxt = tbeo_pkg::ST_INVALID;
        end else if (rc_r[!live_r] != '0 || tag_r[!live_r] != '0 ||
                     phase_r[!live_r] != tbeo_pkg::PH_EMPTY) begin
          st_nxt = tbeo_pkg::ST_REFUSED;
        end else begin
          st_nxt              = tbeo_pkg::ST_DONE;
          phase_nxt[!live_r]  = tbeo_pkg::PH_CANDIDATE;
          tag_nxt[!live_r]    = ep_r;
          res_bank_nxt        = !live_r;
        end
      end
      tbeo_pkg::OP_READY: begin
        st_nxt = tbeo_pkg::ST_PROTOCOL;
        if (efound && phase_r[eb] == tbeo_pkg::PH_CANDIDATE) begin
          st_nxt        = tbeo_pkg::ST_DONE;
          phase_nxt[eb] = tbeo_pkg::PH_READY;
        end
      end
      tbeo_pkg::OP_PUBLISH: begin
        st_nxt = tbeo_pkg::ST_PROTOCOL;
        if (efound && phase_r[eb] == tbeo_pkg::PH_READY && eb != live_r &&
            gen_r != '0 && gen_r != tbeo_pkg::GEN_MAX &&
            phase_r[live_r] == tbeo_pkg::PH_PUBLISHED &&
            live_tag != '0 && ep_gt_live) begin
          st_nxt            = tbeo_pkg::ST_DONE;
          phase_nxt[eb]     = tbeo_pkg::PH_PUBLISHED;
          phase_nxt[live_r] = tbeo_pkg::PH_RETIRING;
          gen_nxt           = gen_r + 1'b1;
          live_nxt          = eb;
          res_epoch_nxt     = ep_r;
          res_bank_nxt      = eb;
          res_gen_nxt       = gen_r + 1'b1;
          pri_epoch_nxt     = live_tag;
          pri_bank_nxt      = live_r;
        end
      end
      tbeo_pkg::OP_ABORT: begin
        st_nxt = tbeo_pkg::ST_REFUSED;
        if (efound && rc_r[eb] == '0 &&
            (phase_r[eb] == tbeo_pkg::PH_CANDIDATE ||
             phase_r[eb] == tbeo_pkg::PH_READY)) begin
          st_nxt        = tbeo_pkg::ST_DONE;
          phase_nxt[eb] = tbeo_pkg::PH_EMPTY;
          tag_nxt[eb]   = '0;
        end
      end
      tbeo_pkg::OP_RETIRE: begin
        if (!efound || phase_r[eb] != tbeo_pkg::PH_RETIRING) begin
          st_nxt = tbeo_pkg::ST_PROTOCOL;
        end else if (rc_r[eb] != '0) begin
          st_nxt = tbeo_pkg::ST_REFUSED;
        end else begin
          st_nxt        = tbeo_pkg::ST_DONE;
          phase_nxt[eb] = tbeo_pkg::PH_EMPTY;
          tag_nxt[eb]   = '0;
        end
      end
      default: st_nxt = tbeo_pkg::ST_INVALID;
    endcase
  end

  // request capture
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_r <= in_op;
      ep_r <= in_epoch;
      bk_r <= in_bank;
      tg_r <= in_ticket_generation;
    end
  end

  // bank state update
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 2; i++) begin
        phase_r[i] <= tbeo_pkg::PH_EMPTY;
        tag_r[i]   <= '0;
        rc_r[i]    <= '0;
      end
      gen_r  <= '0;
      live_r <= 1'b0;
    end else if (cmd.commit) begin
      phase_r <= phase_nxt;
      tag_r   <= tag_nxt;
      rc_r    <= rc_nxt;
      gen_r   <= gen_nxt;
      live_r  <= live_nxt;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      st_r        <= st_nxt;
      res_epoch_r <= res_epoch_nxt;
      res_bank_r  <= res_bank_nxt;
      res_gen_r   <= res_gen_nxt;
      pri_epoch_r <= pri_epoch_nxt;
      pri_bank_r  <= pri_bank_nxt;
    end
  end

  assign out_status            = st_r;
  assign out_result_epoch      = res_epoch_r;
  assign out_result_bank       = res_bank_r;
  assign out_result_generation = res_gen_r;
  assign out_prior_epoch       = pri_epoch_r;
  assign out_prior_bank        = pri_bank_r;

endmodule

FILE: src/two_bank_epoch_ownership_core.sv
// Sequence: the request is captured into the holding registers at the accepting
//   edge and committed into the result register from the evaluate state.
// Flow: the sequencer holds one request at a time and stalls new requests until
//   it commits; evaluation waits only while a stalled result occupies the register.
// Reset: synchronous, active low; both banks empty with zero tag and readers,
//   publish generation zero (uninitialized), live bank 0, no result pending.
// ----------------------------------------------------------------------------
// two_bank_epoch_ownership_core
// Ping-pong ownership manager for two epoch-tagged banks: init, tickets, reserve,
// ready, publish, abort and retire, one status answer per request.
// ----------------------------------------------------------------------------
module two_bank_epoch_ownership_core (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic [tbeo_pkg::OP_W-1:0]        in_op,
  input  logic [tbeo_pkg::EPOCH_W-1:0]     in_epoch,
  input  logic                             in_bank,
  input  logic [tbeo_pkg::GEN_W-1:0]       in_ticket_generation,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic [1:0]                       out_status,
  output logic [tbeo_pkg::EPOCH_W-1:0]     out_result_epoch,
  output logic                             out_result_bank,
  output logic [tbeo_pkg::GEN_W-1:0]       out_result_generation,
  output logic [tbeo_pkg::EPOCH_W-1:0]     out_prior_epoch,
  output logic                             out_prior_bank
);

  tbeo_pkg::cmd_t cmd;

  // request sequencer
  tbeo_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd)
  );

  // bank state and evaluation
  tbeo_dp u_dp (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .cmd                   (cmd),
    .in_op                 (in_op),
    .in_epoch              (in_epoch),
    .in_bank               (in_bank),
    .in_ticket_generation  (in_ticket_generation),
    .out_status            (out_status),
    .out_result_epoch      (out_result_epoch),
    .out_result_bank       (out_result_bank),
    .out_result_generation (out_result_generation),
    .out_prior_epoch       (out_prior_epoch),
    .out_prior_bank        (out_prior_bank)
  );

endmodule
